### rtl/core/fbfa_pkg.sv
// Shared constants, types and reset contents for the region allocator.
`default_nettype none
package fbfa_pkg;

  localparam int FREE_DEPTH = 16;
  localparam int USED_DEPTH = 16;
  localparam int ADDR_BITS  = 24;
  localparam int ID_BITS    = 8;

  localparam int SIZE_W   = 25;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;
  localparam int FREED_W  = 5;

  localparam int FIDX_W    = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int FCNT_W    = $clog2(FREE_DEPTH + 1);
  localparam int UIDX_W    = (USED_DEPTH > 1) ? $clog2(USED_DEPTH) : 1;
  localparam int UCNT_W    = $clog2(USED_DEPTH + 1);
  localparam int MAX_DEPTH = (FREE_DEPTH > USED_DEPTH) ? FREE_DEPTH : USED_DEPTH;
  localparam int PTR_W     = $clog2(MAX_DEPTH + 1);
  localparam int END_W     = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;

  localparam int MIB           = 1048576;
  localparam int RESET_REGIONS = 5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TERM    = 2'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIZE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_LIMIT = 1'b1;
  localparam logic [SIZE_W-1:0]    MERGE_LIMIT_RESET = SIZE_W'(4 * MIB);

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_W-1:0]    len;
  } free_ent_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_W-1:0]    len;
    logic [ID_BITS-1:0]   pid;
    logic [ID_BITS-1:0]   blk;
  } used_ent_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_NEXT,
    CELL_PREV,
    CELL_LOAD
  } cell_op_e;

  function automatic free_ent_t free_reset(int k);
    free_ent_t e;
    e = '0;
    case (k)
      0: begin
        e.start = ADDR_BITS'(3 * MIB);
        e.len   = SIZE_W'(MIB);
      end
      1: begin
        e.start = ADDR_BITS'(4 * MIB);
        e.len   = SIZE_W'(2 * MIB);
      end
      2: begin
        e.start = ADDR_BITS'(6 * MIB);
        e.len   = SIZE_W'(2 * MIB);
      end
      3: begin
        e.start = ADDR_BITS'(8 * MIB);
        e.len   = SIZE_W'(4 * MIB);
      end
      4: begin
        e.start = ADDR_BITS'(12 * MIB);
        e.len   = SIZE_W'(4 * MIB);
      end
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

### rtl/core/fbfa_if.sv
// Valid/ready channel interfaces for allocator commands and responses.
`default_nettype none
interface fbfa_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [fbfa_pkg::MODE_W-1:0]         mode;
  logic [fbfa_pkg::ID_BITS-1:0]        process_id;
  logic [fbfa_pkg::ID_BITS-1:0]        block_id;
  logic [fbfa_pkg::SIZE_W-1:0]         request_size;

  modport source (output valid, mode, process_id, block_id, request_size, input ready);
  modport sink   (input valid, mode, process_id, block_id, request_size, output ready);
endinterface

interface fbfa_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [fbfa_pkg::STATUS_W-1:0]       status;
  logic [fbfa_pkg::ADDR_BITS-1:0]      block_address;
  logic [fbfa_pkg::SIZE_W-1:0]         found_size;
  logic [fbfa_pkg::FREED_W-1:0]        freed_count;

  modport source (output valid, status, block_address, found_size, freed_count, input ready);
  modport sink   (input valid, status, block_address, found_size, freed_count, output ready);
endinterface
`default_nettype wire

### rtl/core/fbfa_free_cell.sv
// One entry of the address-sorted free table with its neighbour compare.
`default_nettype none
module fbfa_free_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  fbfa_pkg::free_ent_t              rst_val_i,
  input  fbfa_pkg::cell_op_e               op_i,
  input  fbfa_pkg::free_ent_t              prev_i,
  input  fbfa_pkg::free_ent_t              next_i,
  input  fbfa_pkg::free_ent_t              load_i,
  input  wire [fbfa_pkg::ADDR_BITS-1:0]    key_i,
  input  wire [fbfa_pkg::SIZE_W-1:0]       limit_i,
  output fbfa_pkg::free_ent_t              ent_o,
  output logic                             lt_o,
  output logic                             join_o,
  output logic [fbfa_pkg::SIZE_W-1:0]      sum_o
);

  fbfa_pkg::free_ent_t ent_q, ent_d;
  logic [fbfa_pkg::END_W-1:0] end_addr;
  logic [fbfa_pkg::SIZE_W:0]  sum;

  always_comb begin
    case (op_i)
      fbfa_pkg::CELL_NEXT: ent_d = next_i;
      fbfa_pkg::CELL_PREV: ent_d = prev_i;
      fbfa_pkg::CELL_LOAD: ent_d = load_i;
      default:             ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= rst_val_i;
    end else begin
      ent_q <= ent_d;
    end
  end

  // neighbour is joinable when it starts where this one ends and the sum stays under the limit
  assign end_addr = fbfa_pkg::END_W'(ent_q.start) + fbfa_pkg::END_W'(ent_q.len);
  assign sum      = {1'b0, ent_q.len} + {1'b0, next_i.len};
  assign join_o   = (end_addr == fbfa_pkg::END_W'(next_i.start)) && (sum < {1'b0, limit_i});
  assign sum_o    = sum[fbfa_pkg::SIZE_W-1:0];
  assign lt_o     = key_i < ent_q.start;
  assign ent_o    = ent_q;

endmodule
`default_nettype wire

### rtl/core/fbfa_used_cell.sv
// One entry of the in-use table in allocation order with its owner match.
`default_nettype none
module fbfa_used_cell (
  input  wire                              clk_i,
  input  fbfa_pkg::cell_op_e               op_i,
  input  fbfa_pkg::used_ent_t              next_i,
  input  fbfa_pkg::used_ent_t              load_i,
  input  wire [fbfa_pkg::ID_BITS-1:0]      pid_i,
  input  wire [fbfa_pkg::ID_BITS-1:0]      blk_i,
  output fbfa_pkg::used_ent_t              ent_o,
  output logic                             pid_match_o,
  output logic                             full_match_o
);

  fbfa_pkg::used_ent_t ent_q, ent_d;

  always_comb begin
    case (op_i)
      fbfa_pkg::CELL_NEXT: ent_d = next_i;
      fbfa_pkg::CELL_LOAD: ent_d = load_i;
      default:             ent_d = ent_q;
    endcase
  end

  // contents are only read below the fill count, so no reset
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign pid_match_o  = ent_q.pid == pid_i;
  assign full_match_o = pid_match_o && (ent_q.blk == blk_i);
  assign ent_o        = ent_q;

endmodule
`default_nettype wire

### rtl/core/first_best_fit_region_allocator_top.sv
// Top level of the first/best fit region allocator: sequencer and two rows of table cells.
// A zero-size allocate goes from idle straight to the response with no space. Otherwise
// the free table is scanned one entry per cycle, first fit stopping at the first adequate
// entry, best fit or a miss to the end, then a commit step updates the tables on success.
// Deallocate and terminate move matching in-use blocks to the free table, then run merge
// passes over neighbouring pairs until none joins, and the word is registered last.
// Throughput: one command at a time; the next is taken once the sequencer is back in idle.
// Reset: asynchronous, active low; free table loads its five regions, in-use table empties.
`default_nettype none
module first_best_fit_region_allocator_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  fbfa_cmd_if.sink                           cmd_i,
  fbfa_rsp_if.source                         rsp_o,
  input  wire                                cfg_we_i,
  input  wire [fbfa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [fbfa_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int FD = fbfa_pkg::FREE_DEPTH;
  localparam int UD = fbfa_pkg::USED_DEPTH;
  localparam int PW = fbfa_pkg::PTR_W;

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ASCAN   = 3'd1;
  localparam logic [2:0] S_ACOMMIT = 3'd2;
  localparam logic [2:0] S_USCAN   = 3'd3;
  localparam logic [2:0] S_MERGE   = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration
  logic                        fit_q;
  logic [fbfa_pkg::SIZE_W-1:0] limit_q;

  // latched command
  logic [fbfa_pkg::MODE_W-1:0]  mode_q, mode_d;
  logic [fbfa_pkg::ID_BITS-1:0] pid_q, pid_d, blk_q, blk_d;
  logic [fbfa_pkg::SIZE_W-1:0]  req_q, req_d;

  // scan and merge bookkeeping
  logic [PW-1:0]                 ptr_q, ptr_d;
  logic                          hit_q, hit_d;
  logic [fbfa_pkg::FIDX_W-1:0]   pick_q, pick_d;
  logic [fbfa_pkg::SIZE_W-1:0]   pick_len_q, pick_len_d;
  logic [fbfa_pkg::ADDR_BITS-1:0] pick_start_q, pick_start_d;
  logic                          merged_q, merged_d;
  logic                          any_q, any_d;
  logic [fbfa_pkg::FCNT_W-1:0]   fcnt_q, fcnt_d;
  logic [fbfa_pkg::UCNT_W-1:0]   ucnt_q, ucnt_d;

  // working result
  logic [fbfa_pkg::STATUS_W-1:0]  st_q, st_d;
  logic [fbfa_pkg::ADDR_BITS-1:0] addr_q, addr_d;
  logic [fbfa_pkg::SIZE_W-1:0]    found_q, found_d;
  logic [fbfa_pkg::FREED_W-1:0]   freed_q, freed_d;

  // output register
  logic                           ov_q, ov_d;
  logic [fbfa_pkg::STATUS_W-1:0]  o_st_q, o_st_d;
  logic [fbfa_pkg::ADDR_BITS-1:0] o_addr_q, o_addr_d;
  logic [fbfa_pkg::SIZE_W-1:0]    o_found_q, o_found_d;
  logic [fbfa_pkg::FREED_W-1:0]   o_freed_q, o_freed_d;

  // free row
  fbfa_pkg::free_ent_t         f_ent  [FD];
  fbfa_pkg::free_ent_t         f_next [FD];
  fbfa_pkg::free_ent_t         f_prev [FD];
  fbfa_pkg::cell_op_e          f_op   [FD];
  logic                        f_lt   [FD];
  logic                        f_join [FD];
  logic [fbfa_pkg::SIZE_W-1:0] f_sum  [FD];

  // used row
  fbfa_pkg::used_ent_t u_ent  [UD];
  fbfa_pkg::used_ent_t u_next [UD];
  fbfa_pkg::cell_op_e  u_op   [UD];
  logic                u_pm   [UD];
  logic                u_fm   [UD];

  // row control from the sequencer
  logic                        f_ins, f_rem, f_load_en;
  logic [PW-1:0]               f_rem_from;
  logic [fbfa_pkg::FIDX_W-1:0] f_load_idx;
  fbfa_pkg::free_ent_t         f_load_val;
  logic [fbfa_pkg::ADDR_BITS-1:0] f_key;
  logic                        u_rem, u_load_en;
  logic [PW-1:0]               u_rem_from;
  logic [fbfa_pkg::UIDX_W-1:0] u_load_idx;
  fbfa_pkg::used_ent_t         u_load_val;

  // entries at the scan pointer
  fbfa_pkg::free_ent_t         f_rd;
  logic                        f_rd_join;
  logic [fbfa_pkg::SIZE_W-1:0] f_rd_sum;
  fbfa_pkg::used_ent_t         u_rd;
  logic                        u_rd_match;

  logic                        cand;
  logic [fbfa_pkg::SIZE_W-1:0] rem_len;

  assign f_rd       = f_ent[ptr_q[fbfa_pkg::FIDX_W-1:0]];
  assign f_rd_join  = f_join[ptr_q[fbfa_pkg::FIDX_W-1:0]];
  assign f_rd_sum   = f_sum[ptr_q[fbfa_pkg::FIDX_W-1:0]];
  assign u_rd       = u_ent[ptr_q[fbfa_pkg::UIDX_W-1:0]];
  assign u_rd_match = (mode_q == fbfa_pkg::MODE_DEALLOC) ? u_fm[ptr_q[fbfa_pkg::UIDX_W-1:0]]
                                                         : u_pm[ptr_q[fbfa_pkg::UIDX_W-1:0]];
  assign f_key      = f_load_val.start;

  // neighbour wiring along both rows; the end cells see an empty entry
  for (genvar k = 0; k < FD; k++) begin : g_free
    if (k == FD - 1) begin : g_last
      assign f_next[k] = '0;
    end else begin : g_mid
      assign f_next[k] = f_ent[k+1];
    end
    if (k == 0) begin : g_first
      assign f_prev[k] = '0;
    end else begin : g_rest
      assign f_prev[k] = f_ent[k-1];
    end

    fbfa_free_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .rst_val_i (fbfa_pkg::free_reset(k)),
      .op_i      (f_op[k]),
      .prev_i    (f_prev[k]),
      .next_i    (f_next[k]),
      .load_i    (f_load_val),
      .key_i     (f_key),
      .limit_i   (limit_q),
      .ent_o     (f_ent[k]),
      .lt_o      (f_lt[k]),
      .join_o    (f_join[k]),
      .sum_o     (f_sum[k])
    );
  end

  for (genvar k = 0; k < UD; k++) begin : g_used
    if (k == UD - 1) begin : g_last
      assign u_next[k] = '0;
    end else begin : g_mid
      assign u_next[k] = u_ent[k+1];
    end

    fbfa_used_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (u_op[k]),
      .next_i       (u_next[k]),
      .load_i       (u_load_val),
      .pid_i        (pid_q),
      .blk_i        (blk_q),
      .ent_o        (u_ent[k]),
      .pid_match_o  (u_pm[k]),
      .full_match_o (u_fm[k])
    );
  end

  // per-cell operation for the free row: an insert opens a gap at the first entry
  // whose start lies above the key, a remove closes up from a given index
  always_comb begin
    logic aft;
    logic prv;
    aft = 1'b0;
    for (int k = 0; k < FD; k++) begin
      prv = aft;
      aft = aft | (fbfa_pkg::FCNT_W'(k) >= fcnt_q) | f_lt[k];
      f_op[k] = fbfa_pkg::CELL_HOLD;
      if (f_ins) begin
        if (prv) begin
          f_op[k] = fbfa_pkg::CELL_PREV;
        end else if (aft) begin
          f_op[k] = fbfa_pkg::CELL_LOAD;
        end
      end else if (f_load_en && (fbfa_pkg::FIDX_W'(k) == f_load_idx)) begin
        f_op[k] = fbfa_pkg::CELL_LOAD;
      end else if (f_rem && (PW'(k) >= f_rem_from)) begin
        f_op[k] = fbfa_pkg::CELL_NEXT;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < UD; k++) begin
      u_op[k] = fbfa_pkg::CELL_HOLD;
      if (u_load_en && (fbfa_pkg::UIDX_W'(k) == u_load_idx)) begin
        u_op[k] = fbfa_pkg::CELL_LOAD;
      end else if (u_rem && (PW'(k) >= u_rem_from)) begin
        u_op[k] = fbfa_pkg::CELL_NEXT;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    pid_d        = pid_q;
    blk_d        = blk_q;
    req_d        = req_q;
    ptr_d        = ptr_q;
    hit_d        = hit_q;
    pick_d       = pick_q;
    pick_len_d   = pick_len_q;
    pick_start_d = pick_start_q;
    merged_d     = merged_q;
    any_d        = any_q;
    fcnt_d       = fcnt_q;
    ucnt_d       = ucnt_q;
    st_d         = st_q;
    addr_d       = addr_q;
    found_d      = found_q;
    freed_d      = freed_q;
    ov_d         = ov_q;
    o_st_d       = o_st_q;
    o_addr_d     = o_addr_q;
    o_found_d    = o_found_q;
    o_freed_d    = o_freed_q;

    f_ins      = 1'b0;
    f_rem      = 1'b0;
    f_rem_from = '0;
    f_load_en  = 1'b0;
    f_load_idx = '0;
    f_load_val = '0;
    u_rem      = 1'b0;
    u_rem_from = '0;
    u_load_en  = 1'b0;
    u_load_idx = '0;
    u_load_val = '0;

    cand    = f_rd.len >= req_q;
    rem_len = pick_len_q - req_q;

    // drop the response word once taken
    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          mode_d   = cmd_i.mode;
          pid_d    = cmd_i.process_id;
          blk_d    = cmd_i.block_id;
          req_d    = cmd_i.request_size;
          ptr_d    = '0;
          hit_d    = 1'b0;
          merged_d = 1'b0;
          any_d    = 1'b0;
          st_d     = fbfa_pkg::ST_NOTFOUND;
          addr_d   = '0;
          found_d  = '0;
          freed_d  = '0;
          case (cmd_i.mode)
            fbfa_pkg::MODE_ALLOC: begin
              if (cmd_i.request_size == '0) begin
                st_d    = fbfa_pkg::ST_NOSPACE;
                state_d = S_DONE;
              end else begin
                state_d = S_ASCAN;
              end
            end
            fbfa_pkg::MODE_DEALLOC: state_d = S_USCAN;
            fbfa_pkg::MODE_TERM:    state_d = S_USCAN;
            default:                state_d = S_DONE;
          endcase
        end
      end

      S_ASCAN: begin
        if (ptr_q < PW'(fcnt_q)) begin
          if (cand && (!hit_q || (fit_q && (f_rd.len < pick_len_q)))) begin
            hit_d        = 1'b1;
            pick_d       = ptr_q[fbfa_pkg::FIDX_W-1:0];
            pick_len_d   = f_rd.len;
            pick_start_d = f_rd.start;
          end
          // first fit stops at the first adequate entry
          if (cand && !fit_q) begin
            state_d = S_ACOMMIT;
          end
          ptr_d = ptr_q + 1'b1;
        end else begin
          state_d = S_ACOMMIT;
        end
      end

      S_ACOMMIT: begin
        state_d = S_DONE;
        if (!hit_q) begin
          st_d = fbfa_pkg::ST_NOSPACE;
        end else if (ucnt_q >= fbfa_pkg::UCNT_W'(UD)) begin
          st_d = fbfa_pkg::ST_FULL;
        end else begin
          st_d    = fbfa_pkg::ST_OK;
          addr_d  = pick_start_q;
          found_d = pick_len_q;
          if (rem_len == '0) begin
            f_rem      = 1'b1;
            f_rem_from = PW'(pick_q);
            fcnt_d     = fcnt_q - 1'b1;
          end else begin
            f_load_en        = 1'b1;
            f_load_idx       = pick_q;
            f_load_val.start = fbfa_pkg::ADDR_BITS'(fbfa_pkg::END_W'(pick_start_q)
                                                    + fbfa_pkg::END_W'(req_q));
            f_load_val.len   = rem_len;
          end
          u_load_en        = 1'b1;
          u_load_idx       = ucnt_q[fbfa_pkg::UIDX_W-1:0];
          u_load_val.start = pick_start_q;
          u_load_val.len   = req_q;
          u_load_val.pid   = pid_q;
          u_load_val.blk   = blk_q;
          ucnt_d           = ucnt_q + 1'b1;
        end
      end

      S_USCAN: begin
        if (ptr_q < PW'(ucnt_q)) begin
          if (u_rd_match) begin
            any_d = 1'b1;
            if (fcnt_q >= fbfa_pkg::FCNT_W'(FD)) begin
              st_d = fbfa_pkg::ST_FULL;
              if (mode_q == fbfa_pkg::MODE_DEALLOC) begin
                state_d = S_DONE;
              end else begin
                ptr_d    = '0;
                merged_d = 1'b0;
                state_d  = S_MERGE;
              end
            end else begin
              // move the block into the free row; the used row closes up under the pointer
              f_ins            = 1'b1;
              f_load_val.start = u_rd.start;
              f_load_val.len   = u_rd.len;
              fcnt_d           = fcnt_q + 1'b1;
              u_rem            = 1'b1;
              u_rem_from       = ptr_q;
              ucnt_d           = ucnt_q - 1'b1;
              if (freed_q == '0) begin
                addr_d = u_rd.start;
              end
              freed_d = freed_q + 1'b1;
              st_d    = fbfa_pkg::ST_OK;
              if (mode_q == fbfa_pkg::MODE_DEALLOC) begin
                ptr_d    = '0;
                merged_d = 1'b0;
                state_d  = S_MERGE;
              end
            end
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end else if (any_q) begin
          ptr_d    = '0;
          merged_d = 1'b0;
          state_d  = S_MERGE;
        end else begin
          st_d    = fbfa_pkg::ST_NOTFOUND;
          state_d = S_DONE;
        end
      end

      S_MERGE: begin
        if (PW'(ptr_q + 1'b1) < PW'(fcnt_q)) begin
          // absorb the right neighbour, then step past it
          if (f_rd_join) begin
            f_load_en        = 1'b1;
            f_load_idx       = ptr_q[fbfa_pkg::FIDX_W-1:0];
            f_load_val.start = f_rd.start;
            f_load_val.len   = f_rd_sum;
            f_rem            = 1'b1;
            f_rem_from       = PW'(ptr_q + 1'b1);
            fcnt_d           = fcnt_q - 1'b1;
            merged_d         = 1'b1;
          end
          ptr_d = ptr_q + 1'b1;
        end else if (merged_q) begin
          ptr_d    = '0;
          merged_d = 1'b0;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d      = 1'b1;
          o_st_d    = st_q;
          o_addr_d  = addr_q;
          o_found_d = found_q;
          o_freed_d = freed_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fit_q    <= 1'b0;
      limit_q  <= fbfa_pkg::MERGE_LIMIT_RESET;
      fcnt_q   <= fbfa_pkg::FCNT_W'(fbfa_pkg::RESET_REGIONS);
      ucnt_q   <= '0;
      ptr_q    <= '0;
      hit_q    <= 1'b0;
      merged_q <= 1'b0;
      any_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      fcnt_q   <= fcnt_d;
      ucnt_q   <= ucnt_d;
      ptr_q    <= ptr_d;
      hit_q    <= hit_d;
      merged_q <= merged_d;
      any_q    <= any_d;
      ov_q     <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fbfa_pkg::CFG_FIT_POLICY:  fit_q   <= cfg_data_i[0];
          fbfa_pkg::CFG_MERGE_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    pid_q        <= pid_d;
    blk_q        <= blk_d;
    req_q        <= req_d;
    pick_q       <= pick_d;
    pick_len_q   <= pick_len_d;
    pick_start_q <= pick_start_d;
    st_q         <= st_d;
    addr_q       <= addr_d;
    found_q      <= found_d;
    freed_q      <= freed_d;
    o_st_q       <= o_st_d;
    o_addr_q     <= o_addr_d;
    o_found_q    <= o_found_d;
    o_freed_q    <= o_freed_d;
  end

  assign cmd_i.ready         = state_q == S_IDLE;
  assign rsp_o.valid         = ov_q;
  assign rsp_o.status        = o_st_q;
  assign rsp_o.block_address = o_addr_q;
  assign rsp_o.found_size    = o_found_q;
  assign rsp_o.freed_count   = o_freed_q;

endmodule
`default_nettype wire

### rtl/core/fbfa_checker.sv
// Port-level checks for the region allocator, bound to the top level.
`default_nettype none
module fbfa_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_valid_i,
  input wire                                in_ready_i,
  input wire                                out_valid_i,
  input wire                                out_ready_i,
  input wire [fbfa_pkg::STATUS_W-1:0]       status_i,
  input wire [fbfa_pkg::ADDR_BITS-1:0]      block_address_i,
  input wire [fbfa_pkg::SIZE_W-1:0]         found_size_i,
  input wire [fbfa_pkg::FREED_W-1:0]        freed_count_i
);

  // a taken command leaves the sequencer busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("allocator took a command while busy");

  // no-space and not-found responses release nothing and report no region size
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i == fbfa_pkg::ST_NOSPACE || status_i == fbfa_pkg::ST_NOTFOUND))
    |-> (freed_count_i == '0 && found_size_i == '0))
    else $error("failed command reports released blocks or a size");

  // never more releases than in-use entries
  a_freed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (freed_count_i <= fbfa_pkg::FREED_W'(fbfa_pkg::USED_DEPTH)))
    else $error("released count exceeds table depth");

  // a stalled response word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(status_i)
      && $stable(block_address_i) && $stable(found_size_i) && $stable(freed_count_i)))
    else $error("response word changed while stalled");

endmodule

bind first_best_fit_region_allocator_top fbfa_checker u_fbfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (cmd_i.valid),
  .in_ready_i      (cmd_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .block_address_i (rsp_o.block_address),
  .found_size_i    (rsp_o.found_size),
  .freed_count_i   (rsp_o.freed_count)
);
`default_nettype wire

### dv/fbfa_checker.sv
// Response checker: watches both channels and predicts every response word of the allocator.
module fbfa_tb_checker (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  fbfa_cmd_if                             cmd,
  fbfa_rsp_if                             rsp,
  input  wire                             cfg_we_i,
  input  wire [fbfa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [fbfa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [fbfa_pkg::STATUS_W-1:0]  status;
    logic [fbfa_pkg::ADDR_BITS-1:0] addr;
    logic [fbfa_pkg::SIZE_W-1:0]    found;
    logic [fbfa_pkg::FREED_W-1:0]   freed;
  } alloc_rsp_t;

  // shadow of the allocator tables
  logic [fbfa_pkg::ADDR_BITS-1:0] hole_base [fbfa_pkg::FREE_DEPTH];
  logic [fbfa_pkg::SIZE_W-1:0]    hole_len  [fbfa_pkg::FREE_DEPTH];
  int                             hole_cnt;
  logic [fbfa_pkg::ADDR_BITS-1:0] grant_base [fbfa_pkg::USED_DEPTH];
  logic [fbfa_pkg::SIZE_W-1:0]    grant_len  [fbfa_pkg::USED_DEPTH];
  logic [fbfa_pkg::ID_BITS-1:0]   grant_pid  [fbfa_pkg::USED_DEPTH];
  logic [fbfa_pkg::ID_BITS-1:0]   grant_blk  [fbfa_pkg::USED_DEPTH];
  int                             grant_cnt;
  logic                           best_fit;
  logic [fbfa_pkg::SIZE_W-1:0]    join_limit;
  alloc_rsp_t                     rsp_queue [$];

  assign pending_o = rsp_queue.size();

  function automatic void drop_hole(int i);
    for (int k = i; k + 1 < hole_cnt; k++) begin
      hole_base[k] = hole_base[k+1];
      hole_len[k]  = hole_len[k+1];
    end
    hole_cnt--;
    hole_base[hole_cnt] = '0;
    hole_len[hole_cnt]  = '0;
  endfunction

  function automatic void drop_grant(int i);
    for (int k = i; k + 1 < grant_cnt; k++) begin
      grant_base[k] = grant_base[k+1];
      grant_len[k]  = grant_len[k+1];
      grant_pid[k]  = grant_pid[k+1];
      grant_blk[k]  = grant_blk[k+1];
    end
    grant_cnt--;
  endfunction

  function automatic bit add_hole(logic [fbfa_pkg::ADDR_BITS-1:0] base,
                                  logic [fbfa_pkg::SIZE_W-1:0] len);
    int pos;
    pos = 0;
    if (hole_cnt >= fbfa_pkg::FREE_DEPTH) return 1'b0;
    while (pos < hole_cnt && !(base < hole_base[pos])) pos++;
    for (int k = hole_cnt; k > pos; k--) begin
      hole_base[k] = hole_base[k-1];
      hole_len[k]  = hole_len[k-1];
    end
    hole_base[pos] = base;
    hole_len[pos]  = len;
    hole_cnt++;
    return 1'b1;
  endfunction

  // join contiguous neighbours; the scan steps past an absorbed entry
  function automatic void coalesce();
    bit          joined;
    int          i;
    logic [26:0] total;
    logic [26:0] tail;
    joined = 1'b1;
    while (joined) begin
      joined = 1'b0;
      i = 0;
      while (i + 1 < hole_cnt) begin
        total = 27'(hole_len[i]) + 27'(hole_len[i+1]);
        tail  = 27'(hole_base[i]) + 27'(hole_len[i]);
        if (tail == 27'(hole_base[i+1]) && total < 27'(join_limit)) begin
          hole_len[i] = fbfa_pkg::SIZE_W'(total);
          drop_hole(i + 1);
          joined = 1'b1;
        end
        i++;
      end
    end
  endfunction

  function automatic alloc_rsp_t predict_rsp(logic [fbfa_pkg::MODE_W-1:0] mode,
                                             logic [fbfa_pkg::ID_BITS-1:0] pid,
                                             logic [fbfa_pkg::ID_BITS-1:0] blk,
                                             logic [fbfa_pkg::SIZE_W-1:0] req);
    alloc_rsp_t r;
    bit         hit;
    bit         any;
    bit         full;
    int         pick;
    int         i;
    r = '0;
    r.status = fbfa_pkg::ST_NOTFOUND;
    hit = 1'b0;
    any = 1'b0;
    full = 1'b0;
    pick = 0;
    case (mode)
      fbfa_pkg::MODE_ALLOC: begin
        if (req != 0) begin
          for (i = 0; i < hole_cnt; i++) begin
            if (hole_len[i] >= req && (!hit || (best_fit && hole_len[i] < hole_len[pick]))) begin
              pick = i;
              hit = 1'b1;
              if (!best_fit) break;
            end
          end
        end
        if (!hit) r.status = fbfa_pkg::ST_NOSPACE;
        else if (grant_cnt >= fbfa_pkg::USED_DEPTH) r.status = fbfa_pkg::ST_FULL;
        else begin
          r.status = fbfa_pkg::ST_OK;
          r.addr   = hole_base[pick];
          r.found  = hole_len[pick];
          grant_base[grant_cnt] = hole_base[pick];
          grant_len[grant_cnt]  = req;
          grant_pid[grant_cnt]  = pid;
          grant_blk[grant_cnt]  = blk;
          grant_cnt++;
          hole_base[pick] = hole_base[pick] + fbfa_pkg::ADDR_BITS'(req);
          hole_len[pick]  = hole_len[pick] - req;
          if (hole_len[pick] == 0) drop_hole(pick);
        end
      end
      fbfa_pkg::MODE_DEALLOC: begin
        for (i = 0; i < grant_cnt; i++)
          if (grant_pid[i] == pid && grant_blk[i] == blk) break;
        if (i < grant_cnt) begin
          if (hole_cnt >= fbfa_pkg::FREE_DEPTH) r.status = fbfa_pkg::ST_FULL;
          else begin
            r.addr = grant_base[i];
            void'(add_hole(grant_base[i], grant_len[i]));
            drop_grant(i);
            coalesce();
            r.status = fbfa_pkg::ST_OK;
            r.freed  = 1;
          end
        end
      end
      fbfa_pkg::MODE_TERM: begin
        i = 0;
        while (i < grant_cnt) begin
          if (grant_pid[i] != pid) begin
            i++;
          end else begin
            any = 1'b1;
            if (!add_hole(grant_base[i], grant_len[i])) begin
              full = 1'b1;
              break;
            end
            if (r.freed == 0) r.addr = grant_base[i];
            r.freed++;
            drop_grant(i);
          end
        end
        if (any) begin
          coalesce();
          r.status = full ? fbfa_pkg::ST_FULL : fbfa_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t exp_rsp;
    if (!rst_ni) begin
      for (int k = 0; k < fbfa_pkg::FREE_DEPTH; k++) begin
        hole_base[k] = '0;
        hole_len[k]  = '0;
      end
      for (int k = 0; k < fbfa_pkg::RESET_REGIONS; k++) begin
        hole_base[k] = fbfa_pkg::ADDR_BITS'((k == 0) ? 3 * fbfa_pkg::MIB :
                                            (k == 1) ? 4 * fbfa_pkg::MIB :
                                            (k == 2) ? 6 * fbfa_pkg::MIB :
                                            (k == 3) ? 8 * fbfa_pkg::MIB :
                                                       12 * fbfa_pkg::MIB);
        hole_len[k]  = fbfa_pkg::SIZE_W'((k == 0) ? fbfa_pkg::MIB :
                                         (k < 3) ? 2 * fbfa_pkg::MIB : 4 * fbfa_pkg::MIB);
      end
      hole_cnt     = fbfa_pkg::RESET_REGIONS;
      grant_cnt    = 0;
      best_fit     = 1'b0;
      join_limit   = fbfa_pkg::MERGE_LIMIT_RESET;
      fail_count_o = 0;
      rsp_queue.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == fbfa_pkg::CFG_FIT_POLICY) best_fit = cfg_data_i[0];
        else if (cfg_idx_i == fbfa_pkg::CFG_MERGE_LIMIT) join_limit = cfg_data_i;
      end
      if (cmd.valid && cmd.ready)
        rsp_queue.push_back(predict_rsp(cmd.mode, cmd.process_id, cmd.block_id,
                                        cmd.request_size));
      if (rsp.valid && rsp.ready) begin
        if (rsp_queue.size() == 0) begin
          $error("response word with nothing outstanding");
          fail_count_o++;
        end else begin
          exp_rsp = rsp_queue.pop_front();
          if (rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
            fail_count_o++;
          end
          if (rsp.block_address !== exp_rsp.addr) begin
            $error("block_address: expected %0h, got %0h", exp_rsp.addr, rsp.block_address);
            fail_count_o++;
          end
          if (rsp.found_size !== exp_rsp.found) begin
            $error("found_size: expected %0h, got %0h", exp_rsp.found, rsp.found_size);
            fail_count_o++;
          end
          if (rsp.freed_count !== exp_rsp.freed) begin
            $error("freed_count: expected %0d, got %0d", exp_rsp.freed, rsp.freed_count);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

### dv/tb.sv
// Testbench top: clock, reset, command and config stimulus, response back-pressure, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // mode code that the block does not implement
  localparam logic [fbfa_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 400;   // longest scan plus merge passes, with margin
  localparam int PHASE_ITEMS    = 220;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [fbfa_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [fbfa_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              fail_count;
  int                              pending;
  int                              cmd_words;
  int                              rsp_words;
  int                              idle_cycles = 0;
  int                              cfg_writes;
  bit                              burst;

  fbfa_cmd_if cmd_if ();
  fbfa_rsp_if rsp_if ();

  first_best_fit_region_allocator_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  fbfa_tb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd          (cmd_if),
    .rsp          (rsp_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Offer one command word: idle for a random gap (none in a burst), then hold valid
  // until the block takes the word at a rising edge.
  task automatic send_cmd(logic [fbfa_pkg::MODE_W-1:0] mode,
                          logic [fbfa_pkg::ID_BITS-1:0] pid,
                          logic [fbfa_pkg::ID_BITS-1:0] blk,
                          logic [fbfa_pkg::SIZE_W-1:0] req);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.mode         <= mode;
    cmd_if.process_id   <= pid;
    cmd_if.block_id     <= blk;
    cmd_if.request_size <= req;
    // ready only moves at rising edges, so look at it between them
    while (!cmd_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    cmd_words++;
  endtask

  // Drop valid and wait until every response is in and the sequencer has settled.
  task automatic drain();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [fbfa_pkg::CFG_IDX_W-1:0] idx,
                           logic [fbfa_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  // Random command: mostly small ids so that frees find their blocks, sometimes the
  // whole id range; sizes mostly small so that the tables fragment and fill.
  task automatic send_random();
    int                           pick;
    int                           szsel;
    logic [fbfa_pkg::MODE_W-1:0]  mode;
    logic [fbfa_pkg::ID_BITS-1:0] pid;
    logic [fbfa_pkg::ID_BITS-1:0] blk;
    logic [fbfa_pkg::SIZE_W-1:0]  req;
    pick  = $urandom_range(0, 99);
    szsel = $urandom_range(0, 99);
    if (pick < 48) mode = fbfa_pkg::MODE_ALLOC;
    else if (pick < 80) mode = fbfa_pkg::MODE_DEALLOC;
    else if (pick < 95) mode = fbfa_pkg::MODE_TERM;
    else mode = MODE_UNUSED;
    pid = ($urandom_range(0, 9) < 8) ? fbfa_pkg::ID_BITS'($urandom_range(0, 3))
                                     : fbfa_pkg::ID_BITS'($urandom_range(0, 255));
    blk = ($urandom_range(0, 9) < 8) ? fbfa_pkg::ID_BITS'($urandom_range(0, 5))
                                     : fbfa_pkg::ID_BITS'($urandom_range(0, 255));
    if (mode != fbfa_pkg::MODE_ALLOC) req = fbfa_pkg::SIZE_W'($urandom());
    else if (szsel < 4) req = '0;
    else if (szsel < 10) req = fbfa_pkg::SIZE_W'($urandom_range(1 << 22, 1 << 24));
    else if (szsel < 65) req = fbfa_pkg::SIZE_W'($urandom_range(1, 1 << 16));
    else req = fbfa_pkg::SIZE_W'($urandom_range(1, 1 << 21));
    send_cmd(mode, pid, blk, req);
  endtask

  // Response side: random ready gaps, plus one long hold-off that lets commands back up.
  initial begin
    int gap;
    rsp_if.ready = 1'b0;
    rsp_words = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (rsp_words == 300) begin
        rsp_if.ready <= 1'b0;
        repeat (600) @(negedge clk_i);
      end else begin
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      rsp_if.ready <= 1'b1;
      while (!rsp_if.valid) @(negedge clk_i);
      @(posedge clk_i);
      rsp_words++;
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [fbfa_pkg::SIZE_W-1:0] limits [7];
    logic                        policies [7];
    cmd_if.valid        = 1'b0;
    cmd_if.mode         = fbfa_pkg::MODE_ALLOC;
    cmd_if.process_id   = '0;
    cmd_if.block_id     = '0;
    cmd_if.request_size = '0;
    cfg_we      = 1'b0;
    cfg_idx     = fbfa_pkg::CFG_FIT_POLICY;
    cfg_data    = '0;
    cmd_words   = 0;
    cfg_writes  = 0;
    burst       = 1'b0;
    rst_ni      = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset tables, zero and oversize requests, exact fits, misses,
    // the unused mode, extreme ids, and a terminate that frees several blocks.
    send_cmd(fbfa_pkg::MODE_ALLOC, 8'd0, 8'd0, '0);
    send_cmd(fbfa_pkg::MODE_ALLOC, 8'd0, 8'd0, fbfa_pkg::SIZE_W'(1 << 24));
    send_cmd(fbfa_pkg::MODE_ALLOC, 8'd1, 8'd1, fbfa_pkg::SIZE_W'(fbfa_pkg::MIB));
    send_cmd(fbfa_pkg::MODE_DEALLOC, 8'd1, 8'd1, '0);
    send_cmd(fbfa_pkg::MODE_DEALLOC, 8'd1, 8'd1, '1);
    send_cmd(fbfa_pkg::MODE_TERM, 8'd9, 8'd0, '0);
    send_cmd(MODE_UNUSED, 8'hff, 8'hff, '1);
    send_cmd(fbfa_pkg::MODE_ALLOC, 8'hff, 8'hff, fbfa_pkg::SIZE_W'(1));
    send_cmd(fbfa_pkg::MODE_ALLOC, 8'hff, 8'h00, fbfa_pkg::SIZE_W'(4 * fbfa_pkg::MIB));
    send_cmd(fbfa_pkg::MODE_ALLOC, 8'h00, 8'hff, fbfa_pkg::SIZE_W'(4 * fbfa_pkg::MIB));
    send_cmd(fbfa_pkg::MODE_ALLOC, 8'h00, 8'h01, fbfa_pkg::SIZE_W'(5 * fbfa_pkg::MIB));
    send_cmd(fbfa_pkg::MODE_ALLOC, 8'h02, 8'h02, fbfa_pkg::SIZE_W'(3));
    send_cmd(fbfa_pkg::MODE_TERM, 8'hff, 8'h00, '0);
    send_cmd(fbfa_pkg::MODE_DEALLOC, 8'h00, 8'hff, '0);
    send_cmd(fbfa_pkg::MODE_TERM, 8'h02, 8'h00, '0);
    send_cmd(fbfa_pkg::MODE_TERM, 8'h00, 8'h00, '0);
    drain();

    // Each phase: new fit policy and merge limit, then random commands.
    policies = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    limits   = '{fbfa_pkg::SIZE_W'(4 * fbfa_pkg::MIB), fbfa_pkg::SIZE_W'(1),
                 fbfa_pkg::SIZE_W'(1 << 24), fbfa_pkg::SIZE_W'(1 << 24),
                 fbfa_pkg::SIZE_W'(1), fbfa_pkg::SIZE_W'($urandom_range(1, 1 << 24)),
                 fbfa_pkg::SIZE_W'(3 * fbfa_pkg::MIB)};
    for (int ph = 0; ph < 7; ph++) begin
      write_cfg(fbfa_pkg::CFG_FIT_POLICY, fbfa_pkg::CFG_DATA_W'(policies[ph]));
      write_cfg(fbfa_pkg::CFG_MERGE_LIMIT, limits[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        // hold the sender once until every response is back
        if (ph == 2 && n == 100) begin
          @(negedge clk_i);
          cmd_if.valid <= 1'b0;
          while (pending != 0) @(posedge clk_i);
        end
        send_random();
      end
      drain();
    end

    $display("tb: %0d commands over %0d register writes, fit policies and merge limits",
             cmd_words, cfg_writes);
    $display("tb: covered including extremes, a long response stall and a sender pause");
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
